@@ sv/assert_macros.svh @@
// Assertion macros shared by the trimmed mean scorer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define TMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that expr holds in the cycle after cond, outside reset.
`define TMS_ASSERT_NEXT(lbl, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ sv/tms_pkg.sv @@
// Shared constants, types and controller states of the trimmed mean scorer.
`default_nettype none

package tms_pkg;

    localparam int ScoreW          = 12;
    localparam int MeanW           = 12;
    localparam int SumOutW         = 16;
    localparam int JudgeCountW     = 5;
    localparam int ScoreCap        = 2560;
    localparam int MinJudges       = 3;
    localparam int TrimDrop        = 2;
    localparam int JudgeCountReset = 3;
    localparam int MaxJudgesDef    = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic group_done;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ sv/tms_div.sv @@
// Restoring divider, one quotient bit per step.
`default_nettype none
`include "assert_macros.svh"

module tms_div #(
    parameter int SUM_W = 16,
    parameter int CNT_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             step,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output logic             last
);
    import tms_pkg::*;

    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W:0]    shifted;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SUM_W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = STEP_W'(SUM_W - 1);
        end
        else if (step)
        begin
            rem_next = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == '0);

    `TMS_ASSERT(a_mean_in_range, (step && last) |=> (quo_reg <= SUM_W'(ScoreCap)), "mean above cap")

endmodule

`default_nettype wire

@@ sv/tms_dp.sv @@
// Datapath: score accumulation, group detection, divider and result registers.
`default_nettype none
`include "assert_macros.svh"

module tms_dp #(
    parameter int MAX_JUDGES = tms_pkg::MaxJudgesDef
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tms_pkg::cmd_t                   cmd,
    output tms_pkg::sts_t                   sts,
    input  logic                            cfg_wen,
    input  logic [tms_pkg::JudgeCountW-1:0] cfg_wdata,
    input  logic [tms_pkg::ScoreW-1:0]      score,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [tms_pkg::MeanW-1:0]       trimmed_mean,
    output logic [tms_pkg::SumOutW-1:0]     total_sum,
    output logic [tms_pkg::ScoreW-1:0]      highest_score,
    output logic [tms_pkg::ScoreW-1:0]      lowest_score
);
    import tms_pkg::*;

    localparam int SumBits = $clog2(MAX_JUDGES * ScoreCap + 1);
    localparam int SUM_W   = (SumBits > SumOutW) ? SumBits : SumOutW;
    localparam int CNT_W   = $clog2(MAX_JUDGES + 1);
    localparam int CMP_W   = (CNT_W > JudgeCountW) ? CNT_W : JudgeCountW;

    logic [JudgeCountW-1:0] judge_count_reg, judge_count_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [ScoreW-1:0]      high_reg, high_next;
    logic [ScoreW-1:0]      low_reg, low_next;
    logic [CNT_W-1:0]       seen_reg, seen_next;
    logic [SUM_W-1:0]       pend_sum_reg, pend_sum_next;
    logic [ScoreW-1:0]      pend_high_reg, pend_high_next;
    logic [ScoreW-1:0]      pend_low_reg, pend_low_next;
    logic                   valid_reg, valid_next;
    logic [MeanW-1:0]       mean_reg, mean_next;
    logic [SumOutW-1:0]     tsum_reg, tsum_next;
    logic [ScoreW-1:0]      ohigh_reg, ohigh_next;
    logic [ScoreW-1:0]      olow_reg, olow_next;

    logic [ScoreW-1:0]      sat;
    logic                   first;
    logic [ScoreW-1:0]      high_new;
    logic [ScoreW-1:0]      low_new;
    logic [SUM_W-1:0]       sum_new;
    logic [CNT_W-1:0]       taken;
    logic [CMP_W-1:0]       taken_c;
    logic [CMP_W-1:0]       jc_c;
    logic                   group_done;
    logic [SUM_W-1:0]       dividend;
    logic [CNT_W-1:0]       divisor;
    logic [SUM_W-1:0]       quotient;
    logic                   div_last;

    always_comb
    begin
        sat        = (score > ScoreW'(ScoreCap)) ? ScoreW'(ScoreCap) : score;
        first      = (seen_reg == '0);
        high_new   = (first || sat > high_reg) ? sat : high_reg;
        low_new    = (first || sat < low_reg) ? sat : low_reg;
        sum_new    = sum_reg + SUM_W'(sat);
        taken      = seen_reg + CNT_W'(1);
        taken_c    = CMP_W'(taken);
        jc_c       = CMP_W'(judge_count_reg);
        group_done = (taken_c >= CMP_W'(MinJudges))
                     && ((taken_c >= jc_c) || (taken_c >= CMP_W'(MAX_JUDGES)));
        dividend   = sum_new - SUM_W'(high_new) - SUM_W'(low_new);
        divisor    = taken - CNT_W'(TrimDrop);
    end

    always_comb
    begin
        judge_count_next = cfg_wen ? cfg_wdata : judge_count_reg;
        sum_next         = sum_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        seen_next        = seen_reg;
        if (cmd.acc_en)
        begin
            if (group_done)
            begin
                sum_next  = '0;
                high_next = '0;
                low_next  = '0;
                seen_next = '0;
            end
            else
            begin
                sum_next  = sum_new;
                high_next = high_new;
                low_next  = low_new;
                seen_next = taken;
            end
        end
        pend_sum_next  = cmd.div_start ? sum_new : pend_sum_reg;
        pend_high_next = cmd.div_start ? high_new : pend_high_reg;
        pend_low_next  = cmd.div_start ? low_new : pend_low_reg;
        valid_next     = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !result_stall)
        begin
            valid_next = 1'b0;
        end
        mean_next  = cmd.out_load ? quotient[MeanW-1:0] : mean_reg;
        tsum_next  = cmd.out_load ? pend_sum_reg[SumOutW-1:0] : tsum_reg;
        ohigh_next = cmd.out_load ? pend_high_reg : ohigh_reg;
        olow_next  = cmd.out_load ? pend_low_reg : olow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            judge_count_reg <= JudgeCountW'(JudgeCountReset);
            sum_reg         <= '0;
            high_reg        <= '0;
            low_reg         <= '0;
            seen_reg        <= '0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            judge_count_reg <= judge_count_next;
            sum_reg         <= sum_next;
            high_reg        <= high_next;
            low_reg         <= low_next;
            seen_reg        <= seen_next;
            valid_reg       <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_sum_reg  <= pend_sum_next;
        pend_high_reg <= pend_high_next;
        pend_low_reg  <= pend_low_next;
        mean_reg      <= mean_next;
        tsum_reg      <= tsum_next;
        ohigh_reg     <= ohigh_next;
        olow_reg      <= olow_next;
    end

    tms_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .step     (cmd.div_step),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .last     (div_last)
    );

    assign sts.group_done = group_done;
    assign sts.div_last   = div_last;
    assign sts.out_free   = !valid_reg || !result_stall;

    assign result_valid  = valid_reg;
    assign trimmed_mean  = mean_reg;
    assign total_sum     = tsum_reg;
    assign highest_score = ohigh_reg;
    assign lowest_score  = olow_reg;

    `TMS_ASSERT(a_load_shows, cmd.out_load |=> result_valid, "loaded beat not shown")

endmodule

`default_nettype wire

@@ sv/tms_ctrl.sv @@
// Controller state machine: accept, divide, hand over the result beat.
`default_nettype none
`include "assert_macros.svh"

module tms_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          score_valid,
    output logic          score_stall,
    input  tms_pkg::sts_t sts,
    output tms_pkg::cmd_t cmd
);
    import tms_pkg::*;

    state_t state_reg, state_next;
    logic   wait_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        score_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                score_stall = 1'b0;
                cmd.acc_en  = score_valid;
                if (score_valid && sts.group_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign wait_busy = (state_reg == ST_WAIT) && !sts.out_free;

    `TMS_ASSERT_NEXT(a_start_divides, cmd.div_start, state_reg == ST_DIV, "divide not entered")
    `TMS_ASSERT_NEXT(a_wait_holds, wait_busy, state_reg == ST_WAIT, "result dropped while busy")

endmodule

`default_nettype wire

@@ sv/trimmed_mean_scorer.sv @@
// Top level of the trimmed mean scorer.
// The last score of a group starts the divider; its result is loaded once the output is free.
// Throughput: one score per cycle within a group; scores then stall until the result is loaded.
// The SUM_W-step restoring divider holds off new scores while it runs.
// Reset: async active low; clears the group, the result valid and sets judge_count to 3.
`default_nettype none

module trimmed_mean_scorer #(
    parameter int MAX_JUDGES = tms_pkg::MaxJudgesDef
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [tms_pkg::JudgeCountW-1:0] cfg_wdata,
    input  logic                            score_valid,
    output logic                            score_stall,
    input  logic [tms_pkg::ScoreW-1:0]      score,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [tms_pkg::MeanW-1:0]       trimmed_mean,
    output logic [tms_pkg::SumOutW-1:0]     total_sum,
    output logic [tms_pkg::ScoreW-1:0]      highest_score,
    output logic [tms_pkg::ScoreW-1:0]      lowest_score
);
    import tms_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tms_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .score_valid (score_valid),
        .score_stall (score_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    tms_dp #(
        .MAX_JUDGES (MAX_JUDGES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .score         (score),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .trimmed_mean  (trimmed_mean),
        .total_sum     (total_sum),
        .highest_score (highest_score),
        .lowest_score  (lowest_score)
    );

endmodule

`default_nettype wire
